/* sv/b64e_pkg.sv */
// Shared types, constants and the sextet-to-character mapping for the base64 encoder.
`timescale 1ns / 1ps

package b64e_pkg;

   // Width of one raw byte and one output character
   localparam int unsigned BYTE_W = 8;
   // Bits in one three-byte group
   localparam int unsigned GROUP_W = 3 * BYTE_W;
   // Group queue depth and its index / fill widths
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

   // Byte counts held in a group
   localparam logic [1:0] HAVE_ONE = 2'd1;
   localparam logic [1:0] HAVE_TWO = 2'd2;
   localparam logic [1:0] HAVE_THREE = 2'd3;

   // Character positions within a group
   localparam logic [1:0] POS_FIRST = 2'd0;
   localparam logic [1:0] POS_SECOND = 2'd1;
   localparam logic [1:0] POS_THIRD = 2'd2;
   localparam logic [1:0] POS_FOURTH = 2'd3;

   // Padding character '='
   localparam logic [BYTE_W-1:0] PAD_CHAR = 8'h3D;

   // One queued group: bytes in order from the top bits down, zero-filled
   typedef struct packed {
      logic [GROUP_W-1:0] group;
      logic [1:0]         have;
      logic               last;
   } q_entry_type;

   // Queue status seen by the front and the top level
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // Map a six-bit value onto the standard alphabet
   function automatic logic [BYTE_W-1:0] sextet_to_char(input logic [5:0] v);
      logic [BYTE_W-1:0] c;
      c = {2'b00, v};
      if (v < 6'd26) begin
         c = 8'h41 + {2'b00, v};
      end else if (v < 6'd52) begin
         c = 8'h61 + ({2'b00, v} - 8'd26);
      end else if (v < 6'd62) begin
         c = 8'h30 + ({2'b00, v} - 8'd52);
      end else if (v == 6'd62) begin
         c = 8'h2B;
      end else begin
         c = 8'h2F;
      end
      return c;
   endfunction

endpackage

/* sv/b64e_front.sv */
// Front end: gathers input bytes into groups of three and pushes finished groups.
`timescale 1ns / 1ps

module b64e_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // [7:0] data_byte
   input  logic                 req_tlast,   // end_of_stream
   input  b64e_pkg::q_status_type q_stat,
   output logic                 push,
   output b64e_pkg::q_entry_type push_entry
);
   import b64e_pkg::*;

   logic [BYTE_W-1:0] byte0_ff, byte0_in;
   logic [BYTE_W-1:0] byte1_ff, byte1_in;
   logic [1:0]        count_ff, count_in;
   logic [1:0]        cnt;
   logic [1:0]        have;
   logic              accept;
   logic [BYTE_W-1:0] b0, b1, b2;

   // Take a byte whenever the queue has room for a group
   assign req_tready = !q_stat.full;
   assign accept = req_tvalid && req_tready;

   // Clamp the unreachable count of three to two
   assign cnt = (count_ff == HAVE_THREE) ? HAVE_TWO : count_ff;
   assign have = cnt + 2'd1;

   // Assemble the group, zero-filling missing bytes
   always_comb begin
      b0 = (cnt == 2'd0) ? req_tdata : byte0_ff;
      b1 = '0;
      if (cnt == HAVE_ONE) begin
         b1 = req_tdata;
      end else if (cnt == HAVE_TWO) begin
         b1 = byte1_ff;
      end
      b2 = (have == HAVE_THREE) ? req_tdata : '0;
   end

   assign push = accept && ((have == HAVE_THREE) || req_tlast);
   assign push_entry = '{group: {b0, b1, b2}, have: have, last: req_tlast};

   // Hold pending bytes; clear the count once a group leaves
   always_comb begin
      byte0_in = byte0_ff;
      byte1_in = byte1_ff;
      count_in = count_ff;
      if (accept) begin
         if (push) begin
            count_in = 2'd0;
         end else begin
            count_in = have;
            if (cnt == 2'd0) begin
               byte0_in = req_tdata;
            end else begin
               byte1_in = req_tdata;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      byte0_ff <= byte0_in;
      byte1_ff <= byte1_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

/* sv/b64e_queue.sv */
// Short group queue between the front end and the character emitter.
`timescale 1ns / 1ps

module b64e_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b64e_pkg::q_entry_type push_entry,
   input  logic                  pop,
   output b64e_pkg::q_entry_type head_entry,
   output b64e_pkg::q_status_type q_stat
);
   import b64e_pkg::*;

   q_entry_type        mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]  fill_ff, fill_in;

   assign q_stat.full = (fill_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_stat.empty = (fill_ff == '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   // Advance pointers and track the fill level
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      fill_in = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         fill_in = fill_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff <= fill_in;
      end
   end

endmodule

/* sv/b64e_back.sv */
// Back end: turns each queued group into four characters, one per cycle while rsp_tready is high.
`timescale 1ns / 1ps

module b64e_back (
   input  logic                  clock,
   input  logic                  reset,
   input  b64e_pkg::q_entry_type head_entry,
   input  b64e_pkg::q_status_type q_stat,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [7:0]            rsp_tdata,   // [7:0] out_char
   output logic [0:0]            rsp_tuser,   // [0] group_last
   output logic                  rsp_tlast    // stream_last
);
   import b64e_pkg::*;

   logic [1:0]        pos_ff, pos_in;
   logic              valid_ff, valid_in;
   logic [BYTE_W-1:0] char_ff, char_in;
   logic              glast_ff, glast_in;
   logic              slast_ff, slast_in;
   logic              load;
   logic              emit;
   logic [5:0]        sextet;

   // Output register is free when empty or being taken
   assign load = !valid_ff || rsp_tready;
   assign emit = load && !q_stat.empty;
   assign pop = emit && (pos_ff == POS_FOURTH);

   // Pick the sextet for the current position
   always_comb begin
      case (pos_ff)
         POS_FIRST:  sextet = head_entry.group[23:18];
         POS_SECOND: sextet = head_entry.group[17:12];
         POS_THIRD:  sextet = head_entry.group[11:6];
         POS_FOURTH: sextet = head_entry.group[5:0];
         default:    sextet = '0;
      endcase
   end

   // Build the next character and its marks
   always_comb begin
      pos_in = pos_ff;
      valid_in = valid_ff;
      char_in = char_ff;
      glast_in = glast_ff;
      slast_in = slast_ff;
      if (emit) begin
         pos_in = pos_ff + 2'd1;
         valid_in = 1'b1;
         char_in = (pos_ff > head_entry.have) ? PAD_CHAR : sextet_to_char(sextet);
         glast_in = (pos_ff == POS_FOURTH);
         slast_in = (pos_ff == POS_FOURTH) && head_entry.last;
      end else if (load) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      glast_ff <= glast_in;
      slast_ff <= slast_in;
      if (reset) begin
         pos_ff <= POS_FIRST;
         valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = char_ff;
   assign rsp_tuser = glast_ff;
   assign rsp_tlast = slast_ff;

endmodule

/* sv/base64_stream_encoder_unit.sv */
// Top level of the base64 stream encoder: front end, group queue and character emitter.
//
//   channel | direction | tdata             | tuser          | tlast
//   req_    | in        | [7:0] data_byte   | -              | end_of_stream
//   rsp_    | out       | [7:0] out_char    | [0] group_last | stream_last
//
// Bytes are taken one per cycle while the group queue has room; each group of three
// (or the partial group closed by tlast) leaves as four characters, one per cycle while
// rsp_tready is high, so the character emitter sets the sustained rate.
// The closing group is queued first; its first character is then registered for output.
// Reset is synchronous and empties the pending bytes, the queue and the output register.
// A stalled rsp_ side fills the four-entry queue before req_tready drops.
`timescale 1ns / 1ps

module base64_stream_encoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tlast,   // end_of_stream
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_char
   output logic [0:0] rsp_tuser,   // [0] group_last
   output logic       rsp_tlast    // stream_last
);
   import b64e_pkg::*;

   q_status_type q_stat;
   q_entry_type  push_entry;
   q_entry_type  head_entry;
   logic         push;
   logic         pop;

   b64e_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_stat     (q_stat),
      .push       (push),
      .push_entry (push_entry)
   );

   b64e_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .q_stat     (q_stat)
   );

   b64e_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_entry (head_entry),
      .q_stat     (q_stat),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Stream end only ever falls on a group's fourth character
   a_slast_on_group_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser[0])
      else $error("stream_last without group_last");

   // Never write into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_stat.full)
      else $error("group queue overflow");

   // Never drain an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !q_stat.empty)
      else $error("group queue underflow");

   // Output register is empty right after reset
   a_reset_clears_out: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule
